### design/vbram_pkg.sv
// Package: word types and operation codes for the view based release-acquire memory.
package vbram_pkg;

  localparam int unsigned OpW = 2;
  localparam logic [OpW-1:0] OP_READ    = 2'd0;
  localparam logic [OpW-1:0] OP_WRITE   = 2'd1;
  localparam logic [OpW-1:0] OP_ADVANCE = 2'd2;
  localparam logic [OpW-1:0] OP_QUERY   = 2'd3;

  localparam int unsigned ORD_ACQ_BIT = 0;
  localparam int unsigned ORD_REL_BIT = 1;

  typedef struct packed {
    logic [1:0]         op;
    logic [1:0]         thread;
    logic [2:0]         location;
    logic signed [31:0] write_value;
    logic [1:0]         order;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [7:0]         advance_mask;
    logic               can_advance;
    logic               status;
  } out_word_t;

endpackage

### design/view_based_release_acquire_memory.sv
// Top level: sequenced release-acquire memory with per-thread views and a message log.
//
// Usage. One input word (op, thread, location, write_value, order) enters on the
// in_valid_i / in_ready_o handshake and produces exactly one result word on
// out_valid_o / out_ready_i. The block works on one word at a time; in_ready_o is
// high only while the sequencer is idle and the output register is free.
//
// A single compare unit and one log view read port are reused per step. Advance, a
// dropped write and a read of an empty log finish at dispatch. A query walks the
// locations one per cycle. A write stores the message view one location per cycle.
// A read scans the log entry by entry (address, then compare on the registered
// memory data), and an acquire read merges the matched view location by location
// (address, wait, compare). in_ready_o returns in the cycle after the result is
// taken.
//
// Reset clears all views, latest stamps and the log fill count at once; view
// flip-flops are small enough to reset directly. Log entries are never read above
// the fill count, so the log memories need no clearing pass.
//
// When the receiver stalls the result waits in the output register and no new
// word is taken until it is delivered.
module view_based_release_acquire_memory
  import vbram_pkg::*;
#(
  parameter int unsigned THREADS   = 4,
  parameter int unsigned LOCATIONS = 8,
  parameter int unsigned LOG_DEPTH = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  localparam int unsigned LW = (LOCATIONS > 1) ? $clog2(LOCATIONS) : 1;
  localparam int unsigned AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LOG_DEPTH + 1);
  localparam int unsigned SW = 9;

  typedef enum logic [3:0] {
    S_IDLE, S_ADV, S_QRY, S_WR_VIEW, S_WR_DONE, S_RD_SCAN, S_RD_CHK,
    S_RD_MERGE, S_RD_MWAIT, S_RD_MCMP, S_DONE
  } state_e;

  state_e state_q;
  in_word_t req_q;
  logic [SW-1:0] view_q [THREADS][LOCATIONS];
  logic [SW-1:0] latest_q [LOCATIONS];
  logic [CW-1:0] count_q;
  logic [AW-1:0] idx_q;
  logic [LW:0]   k_q;
  logic [SW-1:0] want_q, stamp_q;
  out_word_t     res_q;
  logic          out_valid_q;

  // Log memories.
  logic [2:0]    log_loc_mem [LOG_DEPTH];
  logic [31:0]   log_val_mem [LOG_DEPTH];
  logic [SW-1:0] log_view_mem [2**(AW+LW)];
  logic [2:0]    rd_loc_q;
  logic [31:0]   rd_val_q;
  logic [SW-1:0] rd_view_q;

  logic          lw_en, vw_en, vr_en, lr_en;
  logic [AW+LW-1:0] vw_addr, vr_addr;
  logic [SW-1:0] vw_data;

  logic [LW-1:0] k_idx;
  logic [$clog2(THREADS > 1 ? THREADS : 2)-1:0] t_idx;
  logic [LW-1:0] l_idx;
  logic          valid_req;

  assign k_idx = k_q[LW-1:0];
  assign t_idx = req_q.thread[$bits(t_idx)-1:0];
  assign l_idx = req_q.location[LW-1:0];
  assign valid_req = (32'(req_q.thread) < THREADS) && (32'(req_q.location) < LOCATIONS);

  // Shared compare unit: one stamp less-than per cycle.
  logic [SW-1:0] cmp_a, cmp_b;
  logic          cmp_lt;
  always_comb begin
    cmp_a = view_q[t_idx][k_idx];
    cmp_b = latest_q[k_idx];
    if (state_q == S_RD_MCMP) begin
      cmp_a = view_q[t_idx][k_idx];
      cmp_b = rd_view_q;
    end
    cmp_lt = cmp_a < cmp_b;
  end

  always_comb begin
    lw_en   = (state_q == S_WR_DONE);
    vw_en   = (state_q == S_WR_VIEW);
    vw_addr = {idx_q, k_idx};
    vw_data = (k_idx == l_idx) ? stamp_q :
              (req_q.order[ORD_REL_BIT] ? view_q[t_idx][k_idx] : '0);
    lr_en   = (state_q == S_RD_SCAN);
    vr_en   = (state_q == S_RD_SCAN) || (state_q == S_RD_MERGE);
    vr_addr = (state_q == S_RD_SCAN) ? {idx_q, l_idx} : {idx_q, k_idx};
  end

  always_ff @(posedge clk_i) begin
    if (lw_en) begin
      log_loc_mem[idx_q] <= req_q.location;
      log_val_mem[idx_q] <= req_q.write_value;
    end
    if (vw_en) log_view_mem[vw_addr] <= vw_data;
    if (lr_en) begin
      rd_loc_q <= log_loc_mem[idx_q];
      rd_val_q <= log_val_mem[idx_q];
    end
    if (vr_en) rd_view_q <= log_view_mem[vr_addr];
  end

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      idx_q       <= '0;
      k_q         <= '0;
      want_q      <= '0;
      stamp_q     <= '0;
      res_q       <= '0;
      req_q       <= '0;
      for (int t = 0; t < THREADS; t++) begin
        for (int l = 0; l < LOCATIONS; l++) view_q[t][l] <= '0;
      end
      for (int l = 0; l < LOCATIONS; l++) latest_q[l] <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            req_q <= in_data_i;
            res_q <= '0;
            k_q   <= '0;
            idx_q <= '0;
            state_q <= S_ADV;
          end
        end
        // Dispatch cycle: the request register is now loaded.
        S_ADV: begin
          if (!valid_req) begin
            state_q <= S_DONE;
          end else begin
            case (req_q.op)
              OP_READ: begin
                want_q <= view_q[t_idx][l_idx];
                state_q <= (count_q == '0) ? S_DONE : S_RD_SCAN;
              end
              OP_WRITE: begin
                if (32'(count_q) >= LOG_DEPTH) begin
                  res_q.status <= 1'b1;
                  state_q <= S_DONE;
                end else begin
                  stamp_q <= latest_q[l_idx] + 1'b1;
                  latest_q[l_idx] <= latest_q[l_idx] + 1'b1;
                  view_q[t_idx][l_idx] <= latest_q[l_idx] + 1'b1;
                  idx_q <= count_q[AW-1:0];
                  state_q <= S_WR_VIEW;
                end
              end
              OP_ADVANCE: begin
                if (view_q[t_idx][l_idx] < latest_q[l_idx])
                  view_q[t_idx][l_idx] <= view_q[t_idx][l_idx] + 1'b1;
                state_q <= S_DONE;
              end
              default: state_q <= S_QRY;
            endcase
          end
        end
        S_QRY: begin
          if (cmp_lt && k_q < 8) res_q.advance_mask[k_idx[2:0]] <= 1'b1;
          if (cmp_lt) res_q.can_advance <= 1'b1;
          if (32'(k_q) == LOCATIONS - 1) state_q <= S_DONE;
          k_q <= k_q + 1'b1;
        end
        S_WR_VIEW: begin
          if (32'(k_q) == LOCATIONS - 1) state_q <= S_WR_DONE;
          k_q <= k_q + 1'b1;
        end
        S_WR_DONE: begin
          count_q <= count_q + 1'b1;
          state_q <= S_DONE;
        end
        S_RD_SCAN: state_q <= S_RD_CHK;
        S_RD_CHK: begin
          if (rd_loc_q == req_q.location && rd_view_q == want_q) begin
            res_q.read_value <= rd_val_q;
            k_q <= '0;
            state_q <= req_q.order[ORD_ACQ_BIT] ? S_RD_MERGE : S_DONE;
          end else if (CW'(idx_q) + 1'b1 >= count_q) begin
            state_q <= S_DONE;
          end else begin
            idx_q <= idx_q + 1'b1;
            state_q <= S_RD_SCAN;
          end
        end
        S_RD_MERGE: state_q <= S_RD_MWAIT;
        S_RD_MWAIT: state_q <= S_RD_MCMP;
        S_RD_MCMP: begin
          if (cmp_lt) view_q[t_idx][k_idx] <= rd_view_q;
          if (32'(k_q) == LOCATIONS - 1) begin
            state_q <= S_DONE;
          end else begin
            k_q <= k_q + 1'b1;
            state_q <= S_RD_MERGE;
          end
        end
        S_DONE: begin
          out_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### design/vbram_checker.sv
// Checker: port-level properties of the release-acquire memory, bound to the top level.
module vbram_checker
  import vbram_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_word_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_data_o
);

  // A valid result has can_advance set exactly when its advance mask is nonzero.
  a_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.can_advance == (out_data_o.advance_mask != '0)))
    else $error("can_advance disagrees with mask");

  // Never ready while a result is pending.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready with result pending");

  // An accepted word gives no result in the next cycle.
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !out_valid_o) else $error("result too early");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

bind view_based_release_acquire_memory vbram_checker u_vbram_checker (.*);

### tb/tb_view_based_release_acquire_memory.sv
// Self-checking testbench for the view based release-acquire memory.
`timescale 1ns / 1ps

module tb_view_based_release_acquire_memory;
  import vbram_pkg::*;

  localparam int unsigned NumThreads = 4;
  localparam int unsigned NumLocs    = 8;
  localparam int unsigned LogDepth   = 256;
  localparam int unsigned MaxCycles  = 2000000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_data_o;

  view_based_release_acquire_memory u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // The clock runs with a 10 ns period.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Shadow copy of the memory state, updated as each word is accepted.
  logic [8:0]  view_q   [NumThreads][NumLocs];
  logic [8:0]  latest_q [NumLocs];
  logic [2:0]  msg_loc  [LogDepth];
  logic [31:0] msg_val  [LogDepth];
  logic [8:0]  msg_view [LogDepth][NumLocs];
  int unsigned msg_count;

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  int unsigned errors;
  int unsigned cycle_count;
  bit          stim_done;
  bit          calm;  // While set, neither side inserts idle cycles.
  bit          in_fire_q;  // Set when the last rising edge accepted an input word.

  task automatic queue_word(in_word_t w);
    pending_words.insert(pending_words.size(), w);
  endtask

  // Applies one word to the shadow state and returns the result it must produce.
  function automatic out_word_t apply_word(in_word_t w);
    out_word_t r;
    logic [8:0] want;
    logic [8:0] stamp;
    r = '0;
    case (w.op)
      OP_READ: begin
        want = view_q[w.thread][w.location];
        for (int i = 0; i < int'(msg_count); i++) begin
          if (msg_loc[i] == w.location && msg_view[i][w.location] == want) begin
            if (w.order[ORD_ACQ_BIT]) begin
              for (int k = 0; k < NumLocs; k++) begin
                if (msg_view[i][k] > view_q[w.thread][k]) view_q[w.thread][k] = msg_view[i][k];
              end
            end
            r.read_value = msg_val[i];
            break;
          end
        end
      end
      OP_WRITE: begin
        if (msg_count >= LogDepth) begin
          r.status = 1'b1;
        end else begin
          stamp = latest_q[w.location] + 9'd1;
          latest_q[w.location] = stamp;
          view_q[w.thread][w.location] = stamp;
          msg_loc[msg_count] = w.location;
          msg_val[msg_count] = w.write_value;
          for (int k = 0; k < NumLocs; k++) begin
            msg_view[msg_count][k] = w.order[ORD_REL_BIT] ? view_q[w.thread][k] : 9'd0;
          end
          msg_view[msg_count][w.location] = stamp;
          msg_count++;
        end
      end
      OP_ADVANCE: begin
        if (view_q[w.thread][w.location] < latest_q[w.location]) begin
          view_q[w.thread][w.location] += 9'd1;
        end
      end
      default: begin
        for (int k = 0; k < NumLocs; k++) begin
          r.advance_mask[k] = view_q[w.thread][k] < latest_q[k];
        end
        r.can_advance = |r.advance_mask;
      end
    endcase
    return r;
  endfunction

  function automatic in_word_t make_word(logic [1:0] op, logic [1:0] thr, logic [2:0] loc,
                                         logic [31:0] val, logic [1:0] ord);
    in_word_t w;
    w.op = op;
    w.thread = thr;
    w.location = loc;
    w.write_value = val;
    w.order = ord;
    return w;
  endfunction

  function automatic in_word_t random_word();
    logic [1:0] op;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) op = OP_WRITE;
    else if (pick < 70) op = OP_READ;
    else if (pick < 88) op = OP_ADVANCE;
    else op = OP_QUERY;
    // Few locations most of the time, so reads often find matching messages.
    return make_word(op, 2'($urandom_range(0, 3)),
                     3'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 7 : 2)),
                     $urandom, 2'($urandom_range(0, 3)));
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    errors++;
  endtask

  // Driver: presents pending words on the falling edge, holding each until accepted.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_fire_q) begin
        if (in_fire_q) void'(pending_words.pop_front());
        if (pending_words.size() != 0 && (calm || $urandom_range(0, 99) >= 34)) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_words[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= calm || $urandom_range(0, 99) >= 34;
    end
  end

  // Monitor: predicts on each accepted input word and checks each result word.
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      in_fire_q <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o)
        expected_words.insert(expected_words.size(), apply_word(in_data_i));
      if (out_valid_o && out_ready_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", out_data_o.read_value, 32'd0);
        end else begin
          want = expected_words.pop_front();
          if (out_data_o.read_value !== want.read_value)
            report_mismatch("read_value", out_data_o.read_value, want.read_value);
          if (out_data_o.advance_mask !== want.advance_mask)
            report_mismatch("advance_mask", 32'(out_data_o.advance_mask),
                            32'(want.advance_mask));
          if (out_data_o.can_advance !== want.can_advance)
            report_mismatch("can_advance", 32'(out_data_o.can_advance), 32'(want.can_advance));
          if (out_data_o.status !== want.status)
            report_mismatch("status", 32'(out_data_o.status), 32'(want.status));
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    rst_ni      = 1'b0;
    errors      = 0;
    cycle_count = 0;
    stim_done   = 1'b0;
    calm        = 1'b0;
    in_fire_q   = 1'b0;
    msg_count   = 0;
    for (int t = 0; t < NumThreads; t++)
      for (int k = 0; k < NumLocs; k++) view_q[t][k] = '0;
    for (int k = 0; k < NumLocs; k++) latest_q[k] = '0;

    // Directed part: reads at view zero, extreme values, every order, advance limits.
    queue_word(make_word(OP_READ, 2'd0, 3'd0, 32'd0, 2'd1));
    queue_word(make_word(OP_QUERY, 2'd3, 3'd7, 32'hFFFFFFFF, 2'd3));
    queue_word(make_word(OP_ADVANCE, 2'd1, 3'd7, 32'd0, 2'd0));
    queue_word(make_word(OP_WRITE, 2'd0, 3'd0, 32'h80000000, 2'd0));
    queue_word(make_word(OP_WRITE, 2'd0, 3'd7, 32'h7FFFFFFF, 2'd2));
    queue_word(make_word(OP_WRITE, 2'd3, 3'd7, 32'hFFFFFFFF, 2'd3));
    queue_word(make_word(OP_QUERY, 2'd1, 3'd0, 32'd0, 2'd0));
    queue_word(make_word(OP_ADVANCE, 2'd1, 3'd7, 32'd0, 2'd0));
    queue_word(make_word(OP_READ, 2'd1, 3'd7, 32'd0, 2'd1));
    queue_word(make_word(OP_QUERY, 2'd1, 3'd0, 32'd0, 2'd0));
    queue_word(make_word(OP_ADVANCE, 2'd1, 3'd7, 32'd0, 2'd2));
    queue_word(make_word(OP_ADVANCE, 2'd1, 3'd7, 32'd0, 2'd2));
    queue_word(make_word(OP_READ, 2'd1, 3'd7, 32'd0, 2'd3));
    queue_word(make_word(OP_QUERY, 2'd1, 3'd0, 32'd0, 2'd0));
    queue_word(make_word(OP_READ, 2'd2, 3'd0, 32'd0, 2'd2));
    queue_word(make_word(OP_QUERY, 2'd2, 3'd0, 32'd0, 2'd0));

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Random part; the first hundred words run without idling. Later words fill the
    // log past its depth, so dropped writes are exercised as well.
    for (int n = 0; n < 900; n++) begin
      queue_word(random_word());
      if (n == 0) calm = 1'b1;
      if (n == 100) calm = 1'b0;
      while (pending_words.size() > 8 && cycle_count < MaxCycles) @(posedge clk_i);
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while ((pending_words.size() != 0 || expected_words.size() != 0) &&
           cycle_count < MaxCycles) @(posedge clk_i);
    if (cycle_count >= MaxCycles) begin
      $display("RESULT: ERROR");
    end else begin
      repeat (300) @(posedge clk_i);
      if (errors == 0 && expected_words.size() == 0) begin
        $display("RESULT: OK");
      end else begin
        $display("RESULT: ERROR");
      end
    end
    $finish;
  end

endmodule
